// ===== design/lfpu_pkg.sv =====
// lfpu_pkg: constants, register codes and controller/datapath interface types
// for the led frame palette unpacker; no dependencies, used by every module but lfpu_ram

package lfpu_pkg;

   localparam int LED_COUNT     = 96;
   localparam int STICK_LENGTH  = 24;
   localparam int PALETTE_DEPTH = 256;
   localparam int MIRROR_COUNT  = 4;

   localparam int LED_AW = $clog2(LED_COUNT);
   localparam int PAL_AW = $clog2(PALETTE_DEPTH);
   localparam int PIX_W  = $clog2(STICK_LENGTH + 1);
   localparam int POS_W  = $clog2(MIRROR_COUNT * STICK_LENGTH);
   localparam int K_W    = $clog2(MIRROR_COUNT);

   localparam int LED_IDX_W   = 7;
   localparam int COLOR_W     = 24;
   localparam int REQ_DATA_W  = 56;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_BITS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRUECOLOR  = 1'd1;

   localparam logic KIND_PALETTE = 1'b0;
   localparam logic KIND_IMAGE   = 1'b1;

   localparam logic [3:0] INDEX_BITS_RESET = 4'd8;
   localparam logic [3:0] INDEX_BITS_MAX   = 4'd8;

   typedef struct packed {
      logic accept_img;
      logic pal_we;
      logic true_step;
      logic bit_step;
      logic pal_load;
      logic k_clear;
      logic k_inc;
      logic led_rd;
      logic mix;
      logic emit;
      logic pixel_inc;
      logic flush;
   } lfpu_cmd_type;

   typedef struct packed {
      logic truecolor;
      logic phase_last;
      logic pix_room;
      logic idx_done;
      logic bit_last;
      logic more_bits;
      logic pos_ok;
      logic k_last;
      logic pend_valid;
      logic out_free;
   } lfpu_status_type;

endpackage

// ===== design/led_frame_palette_unpacker_top.sv =====
// led_frame_palette_unpacker_top: frame byte and palette write requests in,
// led color writes out; depends on lfpu_pkg, lfpu_ctrl, lfpu_dp, lfpu_ram
//
//   port group   role     contents
//   req_*        slave    palette writes and image bytes
//   rsp_*        master   led color writes, tlast on the final one of a request
//   csr_*        write    index_bits (index 0), truecolor_mode (index 1)
//
// a palette write is taken in idle; an image byte takes a truecolor step in
// truecolor mode, or eight bit steps in palette mode, plus a palette load
// per shown pixel, three steps (read, blend, write) per led write on the single
// led color memory and a flush step. reset clears the counters, held bytes,
// valid bits and truecolor mode and reloads index_bits to 8, with no clearing
// pass (led colors carry valid bits). a stalled rsp side holds the sequencer;
// a new request is taken while the last result still waits.

module led_frame_palette_unpacker_top (
   input  logic                                clock,
   input  logic                                reset,
   // tdata: data_byte, palette_slot, palette_red, palette_green, palette_blue,
   //        blend_on, blend_fraction, zero pad
   input  logic [lfpu_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: kind, frame_start
   input  logic [lfpu_pkg::REQ_USER_W-1:0]     req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: led_index, red, green, blue, zero pad
   output logic [lfpu_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [lfpu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lfpu_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import lfpu_pkg::*;

   lfpu_cmd_type    cmd;
   lfpu_status_type status;

   lfpu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser[0]),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lfpu_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== design/lfpu_ram.sv =====
// lfpu_ram: generic single-write, single-read memory with registered read data
// no dependencies

module lfpu_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/lfpu_ctrl.sv =====
// lfpu_ctrl: sequencer for the unpacker; issues datapath commands per state
// depends on lfpu_pkg

module lfpu_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_kind,
   output logic                      req_tready,
   input  lfpu_pkg::lfpu_status_type status,
   output lfpu_pkg::lfpu_cmd_type    cmd
);

   import lfpu_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_TRUE  = 8'b0000_0010,
      S_BIT   = 8'b0000_0100,
      S_PALLD = 8'b0000_1000,
      S_LEDRD = 8'b0001_0000,
      S_MIX   = 8'b0010_0000,
      S_EMIT  = 8'b0100_0000,
      S_FLUSH = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   state_type after_k;

   // where to go once the current mirror slot is finished
   always_comb begin
      if (status.k_last) begin
         after_k = status.more_bits ? S_BIT : S_FLUSH;
      end else begin
         after_k = S_LEDRD;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_kind == KIND_IMAGE) begin
                  cmd.accept_img = 1'b1;
                  state_in = status.truecolor ? S_TRUE : S_BIT;
               end else begin
                  cmd.pal_we = 1'b1;
               end
            end
         end
         S_TRUE: begin
            cmd.true_step = 1'b1;
            if (status.phase_last && status.pix_room) begin
               cmd.k_clear = 1'b1;
               state_in = S_LEDRD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_BIT: begin
            cmd.bit_step = 1'b1;
            if (status.idx_done && status.pix_room) begin
               state_in = S_PALLD;
            end else if (status.bit_last) begin
               state_in = S_FLUSH;
            end
         end
         S_PALLD: begin
            cmd.pal_load = 1'b1;
            cmd.k_clear  = 1'b1;
            state_in = S_LEDRD;
         end
         S_LEDRD: begin
            if (status.pos_ok) begin
               cmd.led_rd = 1'b1;
               state_in = S_MIX;
            end else begin
               cmd.pixel_inc = status.k_last;
               cmd.k_inc     = !status.k_last;
               state_in = after_k;
            end
         end
         S_MIX: begin
            cmd.mix = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!status.pend_valid || status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.pixel_inc = status.k_last;
               cmd.k_inc     = !status.k_last;
               state_in = after_k;
            end
         end
         S_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/lfpu_dp.sv =====
// lfpu_dp: unpacking counters, palette and led color memories, blend unit,
// pending result and output register; depends on lfpu_pkg and lfpu_ram

module lfpu_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lfpu_pkg::lfpu_cmd_type               cmd,
   output lfpu_pkg::lfpu_status_type            status,
   input  logic [lfpu_pkg::REQ_USER_W-1:0]      req_tuser,
   input  logic [lfpu_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 csr_we,
   input  logic [lfpu_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lfpu_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [lfpu_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast
);

   import lfpu_pkg::*;

   // request fields
   logic                  fs;
   logic [7:0]            data_byte;
   logic [7:0]            palette_slot;
   logic [COLOR_W-1:0]    palette_rgb;
   logic                  blend_on;
   logic [7:0]            blend_fraction;

   assign fs             = req_tuser[1];
   assign data_byte      = req_tdata[7:0];
   assign palette_slot   = req_tdata[15:8];
   assign palette_rgb    = {req_tdata[23:16], req_tdata[31:24], req_tdata[39:32]};
   assign blend_on       = req_tdata[40];
   assign blend_fraction = req_tdata[48:41];

   // configuration
   logic [3:0] index_bits_ff, index_bits_in;
   logic       truecolor_ff, truecolor_in;

   // per-request and unpacking state
   logic [7:0]         byte_ff, byte_in;
   logic               blend_ff, blend_in;
   logic [7:0]         frac_ff, frac_in;
   logic [7:0]         acc_ff, acc_in;
   logic [3:0]         bit_cnt_ff, bit_cnt_in;
   logic [PIX_W-1:0]   pix_ff, pix_in;
   logic [1:0]         phase_ff, phase_in;
   logic [7:0]         held_r_ff, held_r_in;
   logic [7:0]         held_g_ff, held_g_in;
   logic [2:0]         bit_pos_ff, bit_pos_in;
   logic               bits_done_ff, bits_done_in;
   logic [COLOR_W-1:0] rgb_ff, rgb_in;
   logic               idx_oor_ff, idx_oor_in;

   // mirror walk and blend
   logic [K_W-1:0]     k_ff, k_in;
   logic [POS_W-1:0]   base_ff, base_in;
   logic [LED_AW-1:0]  led_ff, led_in;
   logic [LED_COUNT-1:0] led_valid_ff, led_valid_in;
   logic [2:0][7:0]    old_ff, old_in;
   logic [2:0][15:0]   prod_ff, prod_in;
   logic [2:0]         ge_ff, ge_in;

   // pending result and output register
   logic [LED_IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic [COLOR_W-1:0]    pend_rgb_ff, pend_rgb_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                  rsp_tlast_ff, rsp_tlast_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;

   // combinational helpers
   logic [3:0]         width;
   logic               cur_bit;
   logic [7:0]         idx_now;
   logic [3:0]         cnt_inc;
   logic [POS_W-1:0]   pos;
   logic [7:0]         led_calc;
   logic [COLOR_W-1:0] pal_q;
   logic [COLOR_W-1:0] led_q;
   logic [COLOR_W-1:0] new_rgb;
   logic               pal_we;
   logic               out_load;

   always_comb begin
      if (index_bits_ff == 4'd0) begin
         width = 4'd1;
      end else if (index_bits_ff > INDEX_BITS_MAX) begin
         width = INDEX_BITS_MAX;
      end else begin
         width = index_bits_ff;
      end
   end

   assign cur_bit  = byte_ff[bit_pos_ff];
   assign idx_now  = bit_cnt_ff[3] ? acc_ff
                   : (acc_ff | (8'(cur_bit) << bit_cnt_ff[2:0]));
   assign cnt_inc  = 4'(bit_cnt_ff + 4'd1);
   assign pos      = POS_W'(base_ff + POS_W'(pix_ff));
   assign led_calc = 8'(8'(LED_COUNT - 1) - 8'(pos));
   assign pal_we   = cmd.pal_we && ({1'b0, palette_slot} < 9'(PALETTE_DEPTH));
   assign out_load = (cmd.emit && pend_valid_ff) || cmd.flush;

   lfpu_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_DEPTH)) u_palette (
      .clock (clock),
      .we    (pal_we),
      .waddr (palette_slot[PAL_AW-1:0]),
      .wdata (palette_rgb),
      .raddr (idx_now[PAL_AW-1:0]),
      .rdata (pal_q)
   );

   lfpu_ram #(.WIDTH(COLOR_W), .DEPTH(LED_COUNT)) u_led_colors (
      .clock (clock),
      .we    (cmd.emit),
      .waddr (led_ff),
      .wdata (new_rgb),
      .raddr (led_calc[LED_AW-1:0]),
      .rdata (led_q)
   );

   // blend result: old moves toward new by (|new-old| * f) >> 8
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (!blend_ff) begin
            new_rgb[c*8 +: 8] = rgb_ff[c*8 +: 8];
         end else if (ge_ff[c]) begin
            new_rgb[c*8 +: 8] = 8'(old_ff[c] + prod_ff[c][15:8]);
         end else begin
            new_rgb[c*8 +: 8] = 8'(old_ff[c] - prod_ff[c][15:8]);
         end
      end
   end

   always_comb begin
      logic [7:0] old_c;
      logic [7:0] new_c;
      logic [7:0] diff_c;
      old_c  = '0;
      new_c  = '0;
      diff_c = '0;
      old_in  = old_ff;
      prod_in = prod_ff;
      ge_in   = ge_ff;
      if (cmd.mix) begin
         for (int c = 0; c < 3; c++) begin
            old_c  = led_valid_ff[led_ff] ? led_q[c*8 +: 8] : 8'd0;
            new_c  = rgb_ff[c*8 +: 8];
            ge_in[c] = (new_c >= old_c);
            diff_c = (new_c >= old_c) ? 8'(new_c - old_c) : 8'(old_c - new_c);
            old_in[c]  = old_c;
            prod_in[c] = 16'(diff_c * frac_ff);
         end
      end
   end

   always_comb begin
      index_bits_in = index_bits_ff;
      truecolor_in  = truecolor_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_INDEX_BITS: index_bits_in = csr_wdata;
            CSR_TRUECOLOR:  truecolor_in  = csr_wdata[0];
            default:        index_bits_in = index_bits_ff;
         endcase
      end
   end

   always_comb begin
      byte_in      = byte_ff;
      blend_in     = blend_ff;
      frac_in      = frac_ff;
      acc_in       = acc_ff;
      bit_cnt_in   = bit_cnt_ff;
      pix_in       = pix_ff;
      phase_in     = phase_ff;
      held_r_in    = held_r_ff;
      held_g_in    = held_g_ff;
      bit_pos_in   = bit_pos_ff;
      bits_done_in = bits_done_ff;
      rgb_in       = rgb_ff;
      idx_oor_in   = idx_oor_ff;
      k_in         = k_ff;
      base_in      = base_ff;
      led_in       = led_ff;
      led_valid_in = led_valid_ff;

      if (cmd.accept_img) begin
         byte_in      = data_byte;
         blend_in     = blend_on;
         frac_in      = blend_fraction;
         bit_pos_in   = 3'd0;
         bits_done_in = 1'b0;
         if (fs) begin
            acc_in     = '0;
            bit_cnt_in = '0;
            pix_in     = '0;
            phase_in   = '0;
         end
      end

      if (cmd.bit_step) begin
         bit_pos_in   = 3'(bit_pos_ff + 3'd1);
         bits_done_in = (bit_pos_ff == 3'd7);
         if (cnt_inc >= width) begin
            acc_in     = '0;
            bit_cnt_in = '0;
            idx_oor_in = !({1'b0, idx_now} < 9'(PALETTE_DEPTH));
         end else begin
            acc_in     = idx_now;
            bit_cnt_in = cnt_inc;
         end
      end

      if (cmd.true_step) begin
         unique case (phase_ff)
            2'd0: begin
               held_r_in = byte_ff;
               phase_in  = 2'd1;
            end
            2'd1: begin
               held_g_in = byte_ff;
               phase_in  = 2'd2;
            end
            default: begin
               rgb_in   = {held_r_ff, held_g_ff, byte_ff};
               phase_in = 2'd0;
            end
         endcase
      end

      if (cmd.pal_load) begin
         rgb_in = idx_oor_ff ? '0 : pal_q;
      end

      if (cmd.k_clear) begin
         k_in    = '0;
         base_in = '0;
      end else if (cmd.k_inc) begin
         k_in    = K_W'(k_ff + 1'b1);
         base_in = POS_W'(base_ff + POS_W'(STICK_LENGTH));
      end

      if (cmd.pixel_inc) begin
         pix_in = PIX_W'(pix_ff + 1'b1);
      end

      if (cmd.led_rd) begin
         led_in = led_calc[LED_AW-1:0];
      end

      if (cmd.emit) begin
         led_valid_in[led_ff] = 1'b1;
      end
   end

   // a result waits in the pending slot until the next one shows whether it is last
   always_comb begin
      pend_idx_in   = pend_idx_ff;
      pend_rgb_in   = pend_rgb_ff;
      pend_valid_in = pend_valid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (out_load) begin
         rsp_tdata_in  = {1'b0, pend_rgb_ff[7:0], pend_rgb_ff[15:8],
                          pend_rgb_ff[23:16], pend_idx_ff};
         rsp_tlast_in  = cmd.flush;
         rsp_tvalid_in = 1'b1;
      end
      if (cmd.emit) begin
         pend_idx_in   = LED_IDX_W'(led_ff);
         pend_rgb_in   = new_rgb;
         pend_valid_in = 1'b1;
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff <= INDEX_BITS_RESET;
         truecolor_ff  <= 1'b0;
         acc_ff        <= '0;
         bit_cnt_ff    <= '0;
         pix_ff        <= '0;
         phase_ff      <= '0;
         held_r_ff     <= '0;
         held_g_ff     <= '0;
         bit_pos_ff    <= '0;
         bits_done_ff  <= 1'b0;
         k_ff          <= '0;
         base_ff       <= '0;
         led_valid_ff  <= '0;
         pend_valid_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         index_bits_ff <= index_bits_in;
         truecolor_ff  <= truecolor_in;
         acc_ff        <= acc_in;
         bit_cnt_ff    <= bit_cnt_in;
         pix_ff        <= pix_in;
         phase_ff      <= phase_in;
         held_r_ff     <= held_r_in;
         held_g_ff     <= held_g_in;
         bit_pos_ff    <= bit_pos_in;
         bits_done_ff  <= bits_done_in;
         k_ff          <= k_in;
         base_ff       <= base_in;
         led_valid_ff  <= led_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      blend_ff     <= blend_in;
      frac_ff      <= frac_in;
      rgb_ff       <= rgb_in;
      idx_oor_ff   <= idx_oor_in;
      led_ff       <= led_in;
      old_ff       <= old_in;
      prod_ff      <= prod_in;
      ge_ff        <= ge_in;
      pend_idx_ff  <= pend_idx_in;
      pend_rgb_ff  <= pend_rgb_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign status.truecolor  = truecolor_ff;
   assign status.phase_last = phase_ff[1];
   assign status.pix_room   = (pix_ff < PIX_W'(STICK_LENGTH));
   assign status.idx_done   = (cnt_inc >= width);
   assign status.bit_last   = (bit_pos_ff == 3'd7);
   assign status.more_bits  = !truecolor_ff && !bits_done_ff;
   assign status.pos_ok     = (8'(pos) < 8'(LED_COUNT));
   assign status.k_last     = (k_ff == K_W'(MIRROR_COUNT - 1));
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free   = !rsp_tvalid_ff || rsp_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("output register loaded while holding an untaken result");

   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> (!pend_valid_ff && rsp_tvalid_ff && rsp_tlast_ff))
      else $error("flush did not leave a last result in the output register");

   a_led_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (rsp_tdata_ff[LED_IDX_W-1:0] < LED_IDX_W'(LED_COUNT)))
      else $error("led index out of range");

   a_pix_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.pixel_inc |-> (pix_ff < PIX_W'(STICK_LENGTH)))
      else $error("pixel counted past the stick length");

   a_emit_marks: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (pend_valid_ff && led_valid_ff[$past(led_ff)]))
      else $error("led write not recorded");
`endif

endmodule
